### rtl/core/cswt_pkg.sv
// Shared types and constants for the clock / stopwatch / countdown timer.
`timescale 1ns / 1ps
`default_nettype none

package cswt_pkg;

	// Event codes carried in req_type
	typedef enum logic [2:0] {
		REQ_TICK       = 3'd0,
		REQ_SW_CLEAR   = 3'd1,
		REQ_PAUSE      = 3'd2,
		REQ_SEL_SW     = 3'd3,
		REQ_SEL_ENTRY  = 3'd4,
		REQ_SEL_CLOCK  = 3'd5,
		REQ_LOAD_TIMER = 3'd6,
		REQ_LOAD_CLOCK = 3'd7
	} req_kind_t;

	// Display / counting mode
	typedef enum logic [1:0] {
		MODE_CLOCK = 2'd0,
		MODE_SW    = 2'd1,
		MODE_ENTRY = 2'd2,
		MODE_RUN   = 2'd3
	} mode_t;

	// Largest minute or second value
	localparam logic [5:0] MS_TOP       = 6'd59;
	// Stopwatch hours go back to zero on reaching this value
	localparam logic [6:0] SW_HOUR_WRAP = 7'd99;
	// Largest countdown hour value
	localparam logic [6:0] CD_HOUR_TOP  = 7'd99;
	// Clock hours go back to zero on reaching this value
	localparam logic [4:0] CLK_HOUR_WRAP = 5'd24;
	// Largest clock hour value accepted by a load
	localparam logic [6:0] CLK_HOUR_TOP = 7'd23;

	typedef struct packed {
		logic [2:0] req_type;
		logic [6:0] load_hours;
		logic [5:0] load_minutes;
		logic [5:0] load_seconds;
	} req_t;

	typedef struct packed {
		logic [6:0] shown_hours;
		logic [5:0] shown_minutes;
		logic [5:0] shown_seconds;
		logic [1:0] mode_now;
		logic       buzzer_on;
		logic       is_paused;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/core/clock_stopwatch_countdown_timer.sv
// Top level of the clock / stopwatch / countdown timer.
// Each request beat is one event (tick, stopwatch clear, pause/resume, mode
// select, timer load or clock load) and gives exactly one result beat with the
// time shown for the mode after the event, the mode, the buzzer level and the
// paused flag. A request passes an input register, then one update step that
// commits the counters and loads the result register, which offers the result.
// One request is taken every cycle while the result side keeps taking beats;
// a stalled result holds both registers and lowers req_ready only when both
// are full.
`timescale 1ns / 1ps
`default_nettype none

module clock_stopwatch_countdown_timer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire cswt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output cswt_pkg::rsp_t      rsp
);
	import cswt_pkg::*;

	logic beat_valid;
	req_t beat;
	logic take;

	// Register the incoming event
	cswt_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.take      (take),
		.beat_valid(beat_valid),
		.beat      (beat)
	);

	// Update counters and produce the result
	cswt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_valid(beat_valid),
		.beat      (beat),
		.take      (take),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

### rtl/core/cswt_in_stage.sv
// Input register stage: holds one accepted request beat for the update logic.
`timescale 1ns / 1ps
`default_nettype none

module cswt_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire cswt_pkg::req_t req,
	input  wire logic           take,
	output logic                beat_valid,
	output cswt_pkg::req_t      beat
);
	import cswt_pkg::*;

	logic valid_s1;
	req_t req_s1;

	// Accept when the stage is empty or drains this cycle
	assign req_ready  = !valid_s1 || take;
	assign beat_valid = valid_s1;
	assign beat       = req_s1;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

endmodule

`default_nettype wire

### rtl/core/cswt_core.sv
// Counter state, per-event update logic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module cswt_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           beat_valid,
	input  wire cswt_pkg::req_t beat,
	output logic                take,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output cswt_pkg::rsp_t      rsp
);
	import cswt_pkg::*;

	mode_t      mode_q, mode_d;
	logic [6:0] sw_hours_q, sw_hours_d;
	logic [5:0] sw_minutes_q, sw_minutes_d, sw_seconds_q, sw_seconds_d;
	logic [6:0] snap_hours_q, snap_hours_d;
	logic [5:0] snap_minutes_q, snap_minutes_d, snap_seconds_q, snap_seconds_d;
	logic       paused_q, paused_d;
	logic [6:0] cd_hours_q, cd_hours_d;
	logic [5:0] cd_minutes_q, cd_minutes_d, cd_seconds_q, cd_seconds_d;
	logic [4:0] clk_hours_q, clk_hours_d;
	logic [5:0] clk_minutes_q, clk_minutes_d, clk_seconds_q, clk_seconds_d;
	logic       buzzer_q, buzzer_d;

	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;

	req_kind_t kind;

	// Stopwatch advance terms
	logic       sw_sec_wrap, sw_min_wrap;
	logic [5:0] sw_sec_inc, sw_min_inc;
	logic [6:0] sw_hour_bump, sw_hour_inc;

	// Clock advance terms
	logic       clk_sec_wrap, clk_min_wrap;
	logic [5:0] clk_sec_inc, clk_min_inc;
	logic [4:0] clk_hour_bump, clk_hour_inc;

	// Clamped load values
	logic [6:0] cd_load_hours;
	logic [4:0] clk_load_hours;
	logic [5:0] load_min_clamped, load_sec_clamped;

	assign kind      = req_kind_t'(beat.req_type);
	assign take      = beat_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Stopwatch one-second step
	always_comb begin
		sw_sec_wrap  = (sw_seconds_q == MS_TOP);
		sw_min_wrap  = sw_sec_wrap && (sw_minutes_q == MS_TOP);
		sw_sec_inc   = sw_sec_wrap ? 6'd0 : sw_seconds_q + 6'd1;
		sw_min_inc   = sw_min_wrap ? 6'd0 :
			(sw_sec_wrap ? sw_minutes_q + 6'd1 : sw_minutes_q);
		sw_hour_bump = sw_min_wrap ? sw_hours_q + 7'd1 : sw_hours_q;
		sw_hour_inc  = (sw_hour_bump >= SW_HOUR_WRAP) ? 7'd0 : sw_hour_bump;
	end

	// Clock one-second step
	always_comb begin
		clk_sec_wrap  = (clk_seconds_q == MS_TOP);
		clk_min_wrap  = clk_sec_wrap && (clk_minutes_q == MS_TOP);
		clk_sec_inc   = clk_sec_wrap ? 6'd0 : clk_seconds_q + 6'd1;
		clk_min_inc   = clk_min_wrap ? 6'd0 :
			(clk_sec_wrap ? clk_minutes_q + 6'd1 : clk_minutes_q);
		clk_hour_bump = clk_min_wrap ? clk_hours_q + 5'd1 : clk_hours_q;
		clk_hour_inc  = (clk_hour_bump >= CLK_HOUR_WRAP) ? 5'd0 : clk_hour_bump;
	end

	// Clamp load values
	always_comb begin
		cd_load_hours    = (beat.load_hours > CD_HOUR_TOP) ? CD_HOUR_TOP : beat.load_hours;
		clk_load_hours   = (beat.load_hours > CLK_HOUR_TOP) ? CLK_HOUR_TOP[4:0]
			: beat.load_hours[4:0];
		load_min_clamped = (beat.load_minutes > MS_TOP) ? MS_TOP : beat.load_minutes;
		load_sec_clamped = (beat.load_seconds > MS_TOP) ? MS_TOP : beat.load_seconds;
	end

	// Apply one event to the state
	always_comb begin
		mode_d         = mode_q;
		sw_hours_d     = sw_hours_q;
		sw_minutes_d   = sw_minutes_q;
		sw_seconds_d   = sw_seconds_q;
		snap_hours_d   = snap_hours_q;
		snap_minutes_d = snap_minutes_q;
		snap_seconds_d = snap_seconds_q;
		paused_d       = paused_q;
		cd_hours_d     = cd_hours_q;
		cd_minutes_d   = cd_minutes_q;
		cd_seconds_d   = cd_seconds_q;
		clk_hours_d    = clk_hours_q;
		clk_minutes_d  = clk_minutes_q;
		clk_seconds_d  = clk_seconds_q;
		buzzer_d       = buzzer_q;
		case (kind)
			REQ_TICK: begin
				case (mode_q)
					MODE_SW: begin
						sw_hours_d   = sw_hour_inc;
						sw_minutes_d = sw_min_inc;
						sw_seconds_d = sw_sec_inc;
					end
					MODE_CLOCK: begin
						clk_hours_d   = clk_hour_inc;
						clk_minutes_d = clk_min_inc;
						clk_seconds_d = clk_sec_inc;
					end
					MODE_RUN: begin
						// Count down with borrow; toggle the buzzer at zero
						if (cd_seconds_q != 6'd0) begin
							cd_seconds_d = cd_seconds_q - 6'd1;
						end else if (cd_minutes_q != 6'd0) begin
							cd_minutes_d = cd_minutes_q - 6'd1;
							cd_seconds_d = MS_TOP;
						end else if (cd_hours_q != 7'd0) begin
							cd_hours_d   = cd_hours_q - 7'd1;
							cd_minutes_d = MS_TOP;
							cd_seconds_d = MS_TOP;
						end else begin
							buzzer_d = !buzzer_q;
						end
					end
					default: begin
					end
				endcase
			end
			REQ_SW_CLEAR: begin
				sw_hours_d   = 7'd0;
				sw_minutes_d = 6'd0;
				sw_seconds_d = 6'd0;
			end
			REQ_PAUSE: begin
				// Capture on pause, restore on resume
				if (!paused_q) begin
					snap_hours_d   = sw_hours_q;
					snap_minutes_d = sw_minutes_q;
					snap_seconds_d = sw_seconds_q;
					paused_d       = 1'b1;
				end else begin
					sw_hours_d   = snap_hours_q;
					sw_minutes_d = snap_minutes_q;
					sw_seconds_d = snap_seconds_q;
					paused_d     = 1'b0;
				end
			end
			REQ_SEL_SW:    mode_d = MODE_SW;
			REQ_SEL_ENTRY: mode_d = MODE_ENTRY;
			REQ_SEL_CLOCK: mode_d = MODE_CLOCK;
			REQ_LOAD_TIMER: begin
				cd_hours_d   = cd_load_hours;
				cd_minutes_d = load_min_clamped;
				cd_seconds_d = load_sec_clamped;
				mode_d       = MODE_RUN;
			end
			REQ_LOAD_CLOCK: begin
				clk_hours_d   = clk_load_hours;
				clk_minutes_d = load_min_clamped;
				clk_seconds_d = load_sec_clamped;
			end
			default: begin
			end
		endcase
	end

	// Select the shown time for the updated mode
	always_comb begin
		rsp_d.mode_now  = mode_d;
		rsp_d.buzzer_on = buzzer_d;
		rsp_d.is_paused = paused_d;
		case (mode_d)
			MODE_CLOCK: begin
				rsp_d.shown_hours   = {2'b00, clk_hours_d};
				rsp_d.shown_minutes = clk_minutes_d;
				rsp_d.shown_seconds = clk_seconds_d;
			end
			MODE_SW: begin
				if (paused_d) begin
					rsp_d.shown_hours   = snap_hours_d;
					rsp_d.shown_minutes = snap_minutes_d;
					rsp_d.shown_seconds = snap_seconds_d;
				end else begin
					rsp_d.shown_hours   = sw_hours_d;
					rsp_d.shown_minutes = sw_minutes_d;
					rsp_d.shown_seconds = sw_seconds_d;
				end
			end
			default: begin
				rsp_d.shown_hours   = cd_hours_d;
				rsp_d.shown_minutes = cd_minutes_d;
				rsp_d.shown_seconds = cd_seconds_d;
			end
		endcase
	end

	// Commit state on each taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_CLOCK;
			sw_hours_q     <= 7'd0;
			sw_minutes_q   <= 6'd0;
			sw_seconds_q   <= 6'd0;
			snap_hours_q   <= 7'd0;
			snap_minutes_q <= 6'd0;
			snap_seconds_q <= 6'd0;
			paused_q       <= 1'b0;
			cd_hours_q     <= 7'd0;
			cd_minutes_q   <= 6'd0;
			cd_seconds_q   <= 6'd0;
			clk_hours_q    <= 5'd0;
			clk_minutes_q  <= 6'd0;
			clk_seconds_q  <= 6'd0;
			buzzer_q       <= 1'b0;
		end else if (take) begin
			mode_q         <= mode_d;
			sw_hours_q     <= sw_hours_d;
			sw_minutes_q   <= sw_minutes_d;
			sw_seconds_q   <= sw_seconds_d;
			snap_hours_q   <= snap_hours_d;
			snap_minutes_q <= snap_minutes_d;
			snap_seconds_q <= snap_seconds_d;
			paused_q       <= paused_d;
			cd_hours_q     <= cd_hours_d;
			cd_minutes_q   <= cd_minutes_d;
			cd_seconds_q   <= cd_seconds_d;
			clk_hours_q    <= clk_hours_d;
			clk_minutes_q  <= clk_minutes_d;
			clk_seconds_q  <= clk_seconds_d;
			buzzer_q       <= buzzer_d;
		end
	end

	// Hold result valid until the beat is taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp_ready) begin
			rsp_valid_q <= beat_valid;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_clk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(clk_hours_q < CLK_HOUR_WRAP) && (clk_minutes_q <= MS_TOP) && (clk_seconds_q <= MS_TOP))
		else $error("clock counter out of range");

	a_sw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sw_hours_q < SW_HOUR_WRAP) && (sw_minutes_q <= MS_TOP) && (sw_seconds_q <= MS_TOP))
		else $error("stopwatch counter out of range");

	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.mode_now == mode_q) && (rsp_q.is_paused == paused_q)
			&& (rsp_q.buzzer_on == buzzer_q))
		else $error("result flags disagree with committed state");

	a_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (kind == REQ_LOAD_TIMER)) |=> (mode_q == MODE_RUN))
		else $error("timer load did not enter running mode");

	a_no_silent_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> rsp_valid_q)
		else $error("pending result lost");
`endif

endmodule

`default_nettype wire
